// ===== hw/rtl/hcml_pkg.sv =====
// Shared types and constants for the HSV color mask row locator.
`default_nettype none

package hcml_pkg;

   localparam int PIX_W       = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 11;
   localparam int DIM_W       = 11;
   localparam int GAP_W       = 11;
   localparam int RGAP_W      = 12;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   // Reciprocal tables, fixed point with FRAC_BITS fraction bits
   localparam int FRAC_BITS     = 12;
   localparam int SAT_RECIP_NUM = 255 * 4096;
   localparam int HUE_RECIP_NUM = 30 * 4096;
   localparam int SAT_RECIP_W   = 20;
   localparam int HUE_RECIP_W   = 17;
   localparam int RAW_W         = 12;
   localparam int HUE_FULL      = 180;

   localparam int LOCK_MIN_COUNT = 3;
   localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'hFF;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HUE_LOW,
      REG_HUE_HIGH,
      REG_SAT_LOW,
      REG_SAT_HIGH,
      REG_VAL_LOW,
      REG_VAL_HIGH,
      REG_FRAME_WIDTH,
      REG_FRAME_HEIGHT
   } hcml_reg_type;

   typedef struct packed {
      logic [PIX_W-1:0] hue_low;
      logic [PIX_W-1:0] hue_high;
      logic [PIX_W-1:0] sat_low;
      logic [PIX_W-1:0] sat_high;
      logic [PIX_W-1:0] val_low;
      logic [PIX_W-1:0] val_high;
      logic [DIM_W-1:0] frame_width;
      logic [DIM_W-1:0] frame_height;
   } hcml_csr_type;

   localparam hcml_csr_type CSR_RESET = '{
      hue_low:      8'd94,
      hue_high:     8'd126,
      sat_low:      8'd80,
      sat_high:     8'd255,
      val_low:      8'd2,
      val_high:     8'd255,
      frame_width:  11'd64,
      frame_height: 11'd64
   };

   // Classified pixel handed from the classifier to the locator
   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] alpha;
      logic             match;
   } hcml_entry_type;

endpackage

`default_nettype wire

// ===== hw/rtl/hcml_if.sv =====
// Valid/ready channel interfaces for pixels in and masked results out.
`default_nettype none

interface hcml_req_if;
   logic                        valid;
   logic                        ready;
   logic [hcml_pkg::PIX_W-1:0]  pix_blue;
   logic [hcml_pkg::PIX_W-1:0]  pix_green;
   logic [hcml_pkg::PIX_W-1:0]  pix_red;
   logic [hcml_pkg::PIX_W-1:0]  pix_alpha;

   modport source (output valid, pix_blue, pix_green, pix_red, pix_alpha, input ready);
   modport sink (input valid, pix_blue, pix_green, pix_red, pix_alpha, output ready);
endinterface

interface hcml_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [hcml_pkg::PIX_W-1:0]          out_blue;
   logic [hcml_pkg::PIX_W-1:0]          out_green;
   logic [hcml_pkg::PIX_W-1:0]          out_red;
   logic [hcml_pkg::PIX_W-1:0]          out_alpha;
   logic                                in_mask;
   logic                                frame_done;
   logic                                any_match;
   logic [hcml_pkg::GAP_W-1:0]          left_gap;
   logic signed [hcml_pkg::RGAP_W-1:0]  right_gap;

   modport source (output valid, out_blue, out_green, out_red, out_alpha, in_mask,
                   frame_done, any_match, left_gap, right_gap, input ready);
   modport sink (input valid, out_blue, out_green, out_red, out_alpha, in_mask,
                 frame_done, any_match, left_gap, right_gap, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hcml_classify.sv =====
// Front end: pipelined BGR to HSV conversion and bounds test, four stages.
`default_nettype none

module hcml_classify (
   input  wire                        clock,
   input  wire                        reset,
   hcml_req_if.sink                   req,
   input  hcml_pkg::hcml_csr_type     csr,
   input  wire                        q_ready,
   output logic                       q_push,
   output hcml_pkg::hcml_entry_type   q_data
);

   localparam int PW  = hcml_pkg::PIX_W;
   localparam int FB  = hcml_pkg::FRAC_BITS;
   localparam int SRW = hcml_pkg::SAT_RECIP_W;
   localparam int HRW = hcml_pkg::HUE_RECIP_W;
   localparam int RW  = hcml_pkg::RAW_W;
   localparam int SPW = PW + SRW;
   localparam int HPW = RW + HRW + 1;
   localparam int HQW = HPW - FB;
   localparam int SQW = SPW - FB;
   localparam int TAB = 1 << PW;

   // Reciprocal tables, rounded
   logic [SRW-1:0] sat_tab [TAB];
   logic [HRW-1:0] hue_tab [TAB];

   assign sat_tab[0] = '0;
   assign hue_tab[0] = '0;

   for (genvar gi = 1; gi < TAB; gi++) begin : g_recip
      localparam int SatR = (2 * hcml_pkg::SAT_RECIP_NUM + gi) / (2 * gi);
      localparam int HueR = (2 * hcml_pkg::HUE_RECIP_NUM + gi) / (2 * gi);
      assign sat_tab[gi] = SRW'(SatR);
      assign hue_tab[gi] = HRW'(HueR);
   end

   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   // stage 1: max, min, spread, raw hue numerator
   logic [PW-1:0]        vmax_in, vmin_in, diff_in;
   logic [RW-1:0]        raw_in;
   logic [PW-1:0]        s1_v_ff, s1_diff_ff;
   logic signed [RW-1:0] s1_raw_ff;
   logic [4*PW-1:0]      s1_pix_ff;

   // stage 2: reciprocals
   logic [SRW-1:0]       s2_rs_ff;
   logic [HRW-1:0]       s2_rh_ff;
   logic [PW-1:0]        s2_v_ff, s2_diff_ff;
   logic signed [RW-1:0] s2_raw_ff;
   logic [4*PW-1:0]      s2_pix_ff;

   // stage 3: products
   logic [SPW-1:0]        s3_sprod_ff;
   logic signed [HPW-1:0] s3_hprod_ff;
   logic [PW-1:0]         s3_v_ff;
   logic [4*PW-1:0]       s3_pix_ff;

   // stage 4: match decision
   logic                  match_in;
   logic [SPW-1:0]        ssum;
   logic signed [HPW-1:0] hsum;
   logic signed [HQW-1:0] hq, hfix;
   logic [SQW-1:0]        sat_val;
   logic                  s4_match_ff;
   logic [4*PW-1:0]       s4_pix_ff;

   assign adv       = !v4_ff || q_ready;
   assign req.ready = adv;
   assign q_push    = v4_ff && q_ready;
   assign q_data    = {s4_pix_ff, s4_match_ff};

   always_comb begin
      vmax_in = (req.pix_red > req.pix_green) ? req.pix_red : req.pix_green;
      vmin_in = (req.pix_red < req.pix_green) ? req.pix_red : req.pix_green;
      if (req.pix_blue > vmax_in) begin
         vmax_in = req.pix_blue;
      end
      if (req.pix_blue < vmin_in) begin
         vmin_in = req.pix_blue;
      end
      diff_in = vmax_in - vmin_in;
      priority if (vmax_in == req.pix_red) begin
         raw_in = {4'b0, req.pix_green} - {4'b0, req.pix_blue};
      end else if (vmax_in == req.pix_green) begin
         raw_in = {4'b0, req.pix_blue} - {4'b0, req.pix_red} + {3'b0, diff_in, 1'b0};
      end else begin
         raw_in = {4'b0, req.pix_red} - {4'b0, req.pix_green} + {2'b0, diff_in, 2'b0};
      end
   end

   always_comb begin
      ssum    = s3_sprod_ff + SPW'(1 << (FB - 1));
      sat_val = ssum[SPW-1:FB];
      hsum    = s3_hprod_ff + HPW'(1 << (FB - 1));
      hq      = hsum[HPW-1:FB];
      hfix    = (hq < 0) ? hq + HQW'(hcml_pkg::HUE_FULL) : hq;
      match_in = (hfix >= $signed(HQW'(csr.hue_low))) && (hfix <= $signed(HQW'(csr.hue_high)))
              && (sat_val >= SQW'(csr.sat_low)) && (sat_val <= SQW'(csr.sat_high))
              && (s3_v_ff >= csr.val_low) && (s3_v_ff <= csr.val_high);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_v_ff     <= vmax_in;
         s1_diff_ff  <= diff_in;
         s1_raw_ff   <= raw_in;
         s1_pix_ff   <= {req.pix_blue, req.pix_green, req.pix_red, req.pix_alpha};

         s2_rs_ff    <= sat_tab[s1_v_ff];
         s2_rh_ff    <= hue_tab[s1_diff_ff];
         s2_v_ff     <= s1_v_ff;
         s2_diff_ff  <= s1_diff_ff;
         s2_raw_ff   <= s1_raw_ff;
         s2_pix_ff   <= s1_pix_ff;

         s3_sprod_ff <= SPW'(s2_diff_ff) * SPW'(s2_rs_ff);
         s3_hprod_ff <= HPW'(s2_raw_ff) * $signed(HPW'(s2_rh_ff));
         s3_v_ff     <= s2_v_ff;
         s3_pix_ff   <= s2_pix_ff;

         s4_match_ff <= match_in;
         s4_pix_ff   <= s3_pix_ff;
      end
   end

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !q_ready |=> v4_ff && $stable(s4_match_ff) && $stable(s4_pix_ff))
      else $error("classified pixel changed while the queue was full");

endmodule

`default_nettype wire

// ===== hw/rtl/hcml_queue.sv =====
// Short FIFO between the classifier and the row locator.
`default_nettype none

module hcml_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  hcml_pkg::hcml_entry_type   push_data,
   output logic                       push_ready,
   input  wire                        pop,
   output hcml_pkg::hcml_entry_type   pop_data,
   output logic                       pop_valid
);

   localparam int DEPTH = hcml_pkg::QUEUE_DEPTH;
   localparam int PTW   = hcml_pkg::QPTR_W;

   hcml_pkg::hcml_entry_type entry_ff [DEPTH];
   logic [PTW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTW:0]   count_ff;
   logic           do_push, do_pop;

   assign push_ready = (count_ff != (PTW+1)'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTW'(1);
         end
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + (PTW+1)'(1);
            2'b01:   count_ff <= count_ff - (PTW+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTW+1)'(DEPTH))
      else $error("queue occupancy exceeds its depth");

endmodule

`default_nettype wire

// ===== hw/rtl/hcml_locator.sv =====
// Back end: masking, per-row match counting, gap latching and result register.
`default_nettype none

module hcml_locator #(
   parameter int MAX_WIDTH  = hcml_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = hcml_pkg::MAX_HEIGHT_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  hcml_pkg::hcml_csr_type     csr,
   input  wire                        q_valid,
   input  hcml_pkg::hcml_entry_type   q_data,
   output logic                       q_pop,
   hcml_rsp_if.source                 rsp
);

   localparam int PW   = hcml_pkg::PIX_W;
   localparam int GW   = $clog2(MAX_WIDTH + 1);
   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int HW   = $clog2(MAX_HEIGHT + 1);
   localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int SW   = (GW + 2 > hcml_pkg::RGAP_W) ? GW + 2 : hcml_pkg::RGAP_W;
   localparam int LGW  = hcml_pkg::GAP_W;
   localparam int RGW  = hcml_pkg::RGAP_W;

   logic [GW-1:0] width_eff;
   logic [HW-1:0] height_eff;

   logic [CW-1:0]        col_ff;
   logic [RW-1:0]        row_ff;
   logic [GW-1:0]        count_ff, first_gap_ff, held_left_ff;
   logic                 seen_ff, locked_ff, any_ff;
   logic signed [SW-1:0] held_right_ff;

   logic [GW-1:0]        count_in, first_gap_in, held_left_in;
   logic                 seen_in, any_in, locked_in;
   logic signed [SW-1:0] held_right_in;
   logic [GW:0]          gap_sum;
   logic                 row_end, frame_end, m;
   logic [SW-1:0]        left_ext;

   logic                 rsp_valid_ff;
   logic [PW-1:0]        blue_ff, green_ff, red_ff, alpha_ff;
   logic                 mask_ff, done_ff, any_out_ff;
   logic [LGW-1:0]       left_out_ff;
   logic [RGW-1:0]       right_out_ff;

   always_comb begin
      if (csr.frame_width == '0) begin
         width_eff = GW'(1);
      end else if (32'(csr.frame_width) > MAX_WIDTH) begin
         width_eff = GW'(MAX_WIDTH);
      end else begin
         width_eff = GW'(csr.frame_width);
      end
      if (csr.frame_height == '0) begin
         height_eff = HW'(1);
      end else if (32'(csr.frame_height) > MAX_HEIGHT) begin
         height_eff = HW'(MAX_HEIGHT);
      end else begin
         height_eff = HW'(csr.frame_height);
      end
   end

   assign q_pop = q_valid && (!rsp_valid_ff || rsp.ready);
   assign m     = q_data.match;

   always_comb begin
      first_gap_in = seen_ff ? first_gap_ff : first_gap_ff + GW'(1);
      count_in     = count_ff + GW'(m);
      seen_in      = seen_ff || m;
      any_in       = any_ff || m;
      row_end      = ((GW+1)'(col_ff) + (GW+1)'(1)) >= (GW+1)'(width_eff);
      frame_end    = row_end && (((HW+1)'(row_ff) + (HW+1)'(1)) >= (HW+1)'(height_eff));
      gap_sum      = (GW+1)'(first_gap_in) + (GW+1)'(count_in);
      held_left_in  = held_left_ff;
      held_right_in = held_right_ff;
      locked_in     = locked_ff;
      if (row_end && !locked_ff) begin
         held_left_in  = first_gap_in;
         held_right_in = $signed(SW'(width_eff)) - $signed(SW'(gap_sum));
         locked_in     = seen_in && (count_in > GW'(hcml_pkg::LOCK_MIN_COUNT));
      end
      left_ext = SW'(held_left_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         count_ff      <= '0;
         first_gap_ff  <= '0;
         seen_ff       <= 1'b0;
         locked_ff     <= 1'b0;
         any_ff        <= 1'b0;
         held_left_ff  <= '0;
         held_right_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (q_pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (q_pop) begin
            if (row_end) begin
               col_ff       <= '0;
               count_ff     <= '0;
               first_gap_ff <= '0;
               seen_ff      <= 1'b0;
            end else begin
               col_ff       <= col_ff + CW'(1);
               count_ff     <= count_in;
               first_gap_ff <= first_gap_in;
               seen_ff      <= seen_in;
            end
            if (frame_end) begin
               row_ff        <= '0;
               locked_ff     <= 1'b0;
               any_ff        <= 1'b0;
               held_left_ff  <= '0;
               held_right_ff <= '0;
            end else begin
               if (row_end) begin
                  row_ff <= row_ff + RW'(1);
               end
               locked_ff     <= locked_in;
               any_ff        <= any_in;
               held_left_ff  <= held_left_in;
               held_right_ff <= held_right_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         blue_ff      <= m ? q_data.blue  : '0;
         green_ff     <= m ? q_data.green : '0;
         red_ff       <= m ? q_data.red   : '0;
         alpha_ff     <= m ? q_data.alpha : hcml_pkg::ALPHA_OPAQUE;
         mask_ff      <= m;
         done_ff      <= frame_end;
         any_out_ff   <= frame_end && any_in;
         left_out_ff  <= frame_end ? left_ext[LGW-1:0] : '0;
         right_out_ff <= frame_end ? held_right_in[RGW-1:0] : '0;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_blue   = blue_ff;
   assign rsp.out_green  = green_ff;
   assign rsp.out_red    = red_ff;
   assign rsp.out_alpha  = alpha_ff;
   assign rsp.in_mask    = mask_ff;
   assign rsp.frame_done = done_ff;
   assign rsp.any_match  = any_out_ff;
   assign rsp.left_gap   = left_out_ff;
   assign rsp.right_gap  = $signed(right_out_ff);

   a_summary_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !done_ff |-> !any_out_ff && left_out_ff == '0 && right_out_ff == '0)
      else $error("frame summary present outside frame end");

   a_unmatched_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !mask_ff |-> blue_ff == '0 && green_ff == '0 && red_ff == '0
                                   && alpha_ff == hcml_pkg::ALPHA_OPAQUE)
      else $error("unmatched pixel not blanked");

endmodule

`default_nettype wire

// ===== hw/rtl/hsv_color_mask_row_locator_unit.sv =====
// A result is registered after its pixel passes the four HSV stages and a queue entry.
// Throughput: one pixel per cycle while the queue has room; the four-stage HSV pipeline and
// the locator each take one pixel a cycle, and the four-entry queue absorbs output stalls.
// Reset (synchronous, active high) restores the register defaults and starts a new frame.
// Every pixel transaction yields exactly one result transaction.
`default_nettype none

module hsv_color_mask_row_locator_unit #(
   parameter int MAX_WIDTH  = hcml_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = hcml_pkg::MAX_HEIGHT_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_wr_en,
   input  wire [hcml_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [hcml_pkg::CSR_DATA_W-1:0]       csr_wdata,
   hcml_req_if.sink                             req_ch,
   hcml_rsp_if.source                           rsp_ch
);

   localparam int PW = hcml_pkg::PIX_W;
   localparam int DW = hcml_pkg::DIM_W;

   hcml_pkg::hcml_csr_type   csr_ff;
   hcml_pkg::hcml_entry_type push_data, pop_data;
   logic push, push_ready, pop, pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= hcml_pkg::CSR_RESET;
      end else if (csr_wr_en) begin
         unique case (hcml_pkg::hcml_reg_type'(csr_index))
            hcml_pkg::REG_HUE_LOW:      csr_ff.hue_low      <= csr_wdata[PW-1:0];
            hcml_pkg::REG_HUE_HIGH:     csr_ff.hue_high     <= csr_wdata[PW-1:0];
            hcml_pkg::REG_SAT_LOW:      csr_ff.sat_low      <= csr_wdata[PW-1:0];
            hcml_pkg::REG_SAT_HIGH:     csr_ff.sat_high     <= csr_wdata[PW-1:0];
            hcml_pkg::REG_VAL_LOW:      csr_ff.val_low      <= csr_wdata[PW-1:0];
            hcml_pkg::REG_VAL_HIGH:     csr_ff.val_high     <= csr_wdata[PW-1:0];
            hcml_pkg::REG_FRAME_WIDTH:  csr_ff.frame_width  <= csr_wdata[DW-1:0];
            hcml_pkg::REG_FRAME_HEIGHT: csr_ff.frame_height <= csr_wdata[DW-1:0];
         endcase
      end
   end

   hcml_classify u_classify (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .csr     (csr_ff),
      .q_ready (push_ready),
      .q_push  (push),
      .q_data  (push_data)
   );

   hcml_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_data   (pop_data),
      .pop_valid  (pop_valid)
   );

   hcml_locator #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_locator (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr_ff),
      .q_valid (pop_valid),
      .q_data  (pop_data),
      .q_pop   (pop),
      .rsp     (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== test/hsv_color_mask_row_locator_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the HSV color mask row locator unit.
module hsv_color_mask_row_locator_unit_test;
   import hcml_pkg::*;

   localparam int MAX_W         = MAX_WIDTH_DEF;
   localparam int MAX_H         = MAX_HEIGHT_DEF;
   localparam int PIXEL_TARGET  = 1450;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] alpha;
   } bgra_type;

   typedef struct packed {
      logic [PIX_W-1:0]  blue;
      logic [PIX_W-1:0]  green;
      logic [PIX_W-1:0]  red;
      logic [PIX_W-1:0]  alpha;
      logic              mask;
      logic              done;
      logic              any;
      logic [GAP_W-1:0]  left_gap;
      logic [RGAP_W-1:0] right_gap;
   } masked_pixel_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   hcml_req_if req_ch ();
   hcml_rsp_if rsp_ch ();

   hsv_color_mask_row_locator_unit #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   always #5 clock = ~clock;

   // locator model state
   hcml_csr_type cfg_model;
   int col_pos, row_pos, row_hits, row_lead, lock_left, lock_right;
   bit row_hit_seen, row_locked, frame_hit;

   masked_pixel_type pending_pixels[$];
   int  errors, pixels_sent, frames_seen, hits_seen, csr_writes;
   bit  gaps_on, stalls_on;
   int  stall_left;

   // idle burst length: mostly short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void pixel_to_hsv(input int b, input int g, input int r,
                                        output int h, output int s, output int v);
      int mn, diff, raw, sat_recip, hue_recip;
      v = (r > g) ? r : g;
      mn = (r < g) ? r : g;
      if (b > v) v = b;
      if (b < mn) mn = b;
      diff = v - mn;
      sat_recip = (v == 0) ? 0 : (2 * SAT_RECIP_NUM + v) / (2 * v);
      s = (diff * sat_recip + (1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (v == r) raw = g - b;
      else if (v == g) raw = b - r + 2 * diff;
      else raw = r - g + 4 * diff;
      hue_recip = (diff == 0) ? 0 : (2 * HUE_RECIP_NUM + diff) / (2 * diff);
      // arithmetic shift gives the floor for negative hues
      h = (raw * hue_recip + (1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (h < 0) h += HUE_FULL;
   endfunction

   function automatic bit pixel_in_bounds(bgra_type p);
      int h, s, v;
      pixel_to_hsv(int'(p.blue), int'(p.green), int'(p.red), h, s, v);
      return h >= int'(cfg_model.hue_low) && h <= int'(cfg_model.hue_high) &&
             s >= int'(cfg_model.sat_low) && s <= int'(cfg_model.sat_high) &&
             v >= int'(cfg_model.val_low) && v <= int'(cfg_model.val_high);
   endfunction

   function automatic int clamp_dim(int d, int lim);
      if (d == 0) return 1;
      return (d > lim) ? lim : d;
   endfunction

   task automatic predict_masked_pixel(input bgra_type p);
      masked_pixel_type e;
      int  w, hgt;
      bit  hit, row_end, frame_end;
      w = clamp_dim(int'(cfg_model.frame_width), MAX_W);
      hgt = clamp_dim(int'(cfg_model.frame_height), MAX_H);
      hit = pixel_in_bounds(p);
      if (!row_hit_seen) row_lead++;
      if (hit) begin
         row_hits++;
         row_hit_seen = 1'b1;
         frame_hit = 1'b1;
         hits_seen++;
      end
      e = '0;
      e.blue = hit ? p.blue : '0;
      e.green = hit ? p.green : '0;
      e.red = hit ? p.red : '0;
      e.alpha = hit ? p.alpha : ALPHA_OPAQUE;
      e.mask = hit;
      row_end = col_pos + 1 >= w;
      frame_end = row_end && (row_pos + 1 >= hgt);
      if (row_end) begin
         if (!row_locked) begin
            lock_left = row_lead;
            lock_right = w - (row_lead + row_hits);
            if (row_hit_seen && row_hits > LOCK_MIN_COUNT) row_locked = 1'b1;
         end
         row_hits = 0;
         row_lead = 0;
         row_hit_seen = 1'b0;
         col_pos = 0;
         row_pos++;
      end else begin
         col_pos++;
      end
      if (frame_end) begin
         e.done = 1'b1;
         e.any = frame_hit;
         e.left_gap = GAP_W'(lock_left);
         e.right_gap = RGAP_W'(lock_right);  // wraps when below range
         row_pos = 0;
         row_locked = 1'b0;
         lock_left = 0;
         lock_right = 0;
         frame_hit = 1'b0;
         frames_seen++;
      end
      pending_pixels.push_back(e);
   endtask

   task automatic send_pixel(input bgra_type p);
      int gap;
      gap = (gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pix_blue <= p.blue;
      req_ch.pix_green <= p.green;
      req_ch.pix_red <= p.red;
      req_ch.pix_alpha <= p.alpha;
      do @(posedge clock); while (!req_ch.ready);
      predict_masked_pixel(p);
      pixels_sent++;
   endtask

   // drop valid and wait until every pixel in flight has come back
   task automatic settle_block();
      req_ch.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input hcml_reg_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_HUE_LOW:      cfg_model.hue_low = val[PIX_W-1:0];
         REG_HUE_HIGH:     cfg_model.hue_high = val[PIX_W-1:0];
         REG_SAT_LOW:      cfg_model.sat_low = val[PIX_W-1:0];
         REG_SAT_HIGH:     cfg_model.sat_high = val[PIX_W-1:0];
         REG_VAL_LOW:      cfg_model.val_low = val[PIX_W-1:0];
         REG_VAL_HIGH:     cfg_model.val_high = val[PIX_W-1:0];
         REG_FRAME_WIDTH:  cfg_model.frame_width = val;
         REG_FRAME_HEIGHT: cfg_model.frame_height = val;
         default: ;
      endcase
      csr_writes++;
   endtask

   // 8-bit registers get junk in the unused upper bits
   task automatic apply_config(input hcml_csr_type c);
      settle_block();
      write_reg(REG_HUE_LOW, {3'($urandom), c.hue_low});
      write_reg(REG_HUE_HIGH, {3'($urandom), c.hue_high});
      write_reg(REG_SAT_LOW, {3'($urandom), c.sat_low});
      write_reg(REG_SAT_HIGH, {3'($urandom), c.sat_high});
      write_reg(REG_VAL_LOW, {3'($urandom), c.val_low});
      write_reg(REG_VAL_HIGH, {3'($urandom), c.val_high});
      write_reg(REG_FRAME_WIDTH, c.frame_width);
      write_reg(REG_FRAME_HEIGHT, c.frame_height);
   endtask

   function automatic bgra_type random_pixel();
      return bgra_type'($urandom);
   endfunction

   function automatic logic [PIX_W-1:0] jitter(logic [PIX_W-1:0] c);
      int x;
      x = int'(c) + int'($urandom_range(0, 12)) - 6;
      if (x < 0) x = 0;
      if (x > 255) x = 255;
      return PIX_W'(x);
   endfunction

   function automatic bgra_type phase_pixel(bgra_type t);
      bgra_type p;
      int r;
      r = $urandom_range(0, 99);
      p = random_pixel();
      if (r < 65) begin
         p.blue = jitter(t.blue);
         p.green = jitter(t.green);
         p.red = jitter(t.red);
      end else if (r >= 90) begin
         p.blue = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         p.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         p.red = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
      return p;
   endfunction

   // HSV window around a target color, sometimes crossed, open or arbitrary
   function automatic hcml_csr_type bounds_around(bgra_type t);
      hcml_csr_type c;
      int h, s, v, span;
      pixel_to_hsv(int'(t.blue), int'(t.green), int'(t.red), h, s, v);
      c = cfg_model;
      span = $urandom_range(0, 25);
      c.hue_low = PIX_W'((h > span) ? h - span : 0);
      c.hue_high = PIX_W'((h + span < HUE_FULL - 1) ? h + span : HUE_FULL - 1);
      span = $urandom_range(0, 60);
      c.sat_low = PIX_W'((s > span) ? s - span : 0);
      c.sat_high = PIX_W'((s + span < 255) ? s + span : 255);
      span = $urandom_range(0, 60);
      c.val_low = PIX_W'((v > span) ? v - span : 0);
      c.val_high = PIX_W'((v + span < 255) ? v + span : 255);
      case ($urandom_range(0, 19))
         0: c.hue_low = c.hue_high + 8'd1;
         1: c.sat_low = c.sat_high + 8'd1;
         2: c.val_low = c.val_high + 8'd1;
         3: begin
            c.hue_low = '0;
            c.hue_high = 8'd255;
            c.sat_low = '0;
            c.sat_high = 8'd255;
            c.val_low = '0;
            c.val_high = 8'd255;
         end
         4: begin
            c.hue_low = PIX_W'($urandom);
            c.hue_high = PIX_W'($urandom);
            c.sat_low = PIX_W'($urandom);
            c.sat_high = PIX_W'($urandom);
            c.val_low = PIX_W'($urandom);
            c.val_high = PIX_W'($urandom);
         end
         5: c.hue_high = 8'd255;
         default: ;
      endcase
      return c;
   endfunction

   function automatic logic [DIM_W-1:0] small_dim(int hi);
      if ($urandom_range(0, 9) == 0) return '0;
      return DIM_W'($urandom_range(1, hi));
   endfunction

   // pad the current frame out so the next pixel starts a new one
   task automatic align_frame();
      while (col_pos != 0 || row_pos != 0) send_pixel(random_pixel());
   endtask

   task automatic check_field(input string name, input logic [RGAP_W-1:0] want,
                              input logic [RGAP_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic check_result();
      masked_pixel_type want;
      if (pending_pixels.size() == 0) begin
         $display("%0t: unexpected result transaction, mask %b done %b", $time,
                  rsp_ch.in_mask, rsp_ch.frame_done);
         errors++;
         return;
      end
      want = pending_pixels.pop_front();
      check_field("out_blue", RGAP_W'(want.blue), RGAP_W'(rsp_ch.out_blue));
      check_field("out_green", RGAP_W'(want.green), RGAP_W'(rsp_ch.out_green));
      check_field("out_red", RGAP_W'(want.red), RGAP_W'(rsp_ch.out_red));
      check_field("out_alpha", RGAP_W'(want.alpha), RGAP_W'(rsp_ch.out_alpha));
      check_field("in_mask", RGAP_W'(want.mask), RGAP_W'(rsp_ch.in_mask));
      check_field("frame_done", RGAP_W'(want.done), RGAP_W'(rsp_ch.frame_done));
      check_field("any_match", RGAP_W'(want.any), RGAP_W'(rsp_ch.any_match));
      check_field("left_gap", RGAP_W'(want.left_gap), RGAP_W'(rsp_ch.left_gap));
      check_field("right_gap", want.right_gap, rsp_ch.right_gap);
   endtask

   // result checker and output backpressure
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) check_result();
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (stalls_on && $urandom_range(0, 7) == 0) stall_left = pick_gap();
      end
   end

   task automatic test_reset_defaults();
      bgra_type colors[5];
      colors = '{'{255, 0, 0, 0}, '{255, 255, 0, 128}, '{0, 0, 255, 255},
                 '{0, 0, 0, 7}, '{255, 255, 255, 200}};
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      foreach (colors[i]) send_pixel(colors[i]);
   endtask

   // width drops under the current column, then height under the current row
   task automatic test_geometry_change();
      hcml_csr_type c;
      c = cfg_model;
      c.frame_width = 11'd1;
      c.frame_height = 11'd2047;
      apply_config(c);
      gaps_on = 1'b1;
      repeat (6) send_pixel(random_pixel());
      c.frame_height = 11'd3;
      apply_config(c);
      repeat (2) send_pixel(random_pixel());
   endtask

   task automatic test_full_range_colors();
      hcml_csr_type c;
      bgra_type colors[8];
      colors = '{'{0, 0, 0, 0}, '{255, 255, 255, 255}, '{255, 0, 0, 128},
                 '{0, 255, 0, 1}, '{0, 0, 255, 254}, '{255, 255, 0, 85},
                 '{0, 255, 255, 170}, '{255, 0, 255, 15}};
      c = '{hue_low: 8'd0, hue_high: 8'd179, sat_low: 8'd0, sat_high: 8'd255,
            val_low: 8'd0, val_high: 8'd255, frame_width: 11'd4, frame_height: 11'd2};
      apply_config(c);
      stalls_on = 1'b1;
      align_frame();
      foreach (colors[i]) send_pixel(colors[i]);
   endtask

   task automatic test_crossed_bounds();
      hcml_csr_type c;
      for (int comp = 0; comp < 3; comp++) begin
         c = '{hue_low: 8'd0, hue_high: 8'd179, sat_low: 8'd0, sat_high: 8'd255,
               val_low: 8'd0, val_high: 8'd255, frame_width: 11'd2, frame_height: 11'd1};
         case (comp)
            0: begin c.hue_low = 8'd150; c.hue_high = 8'd20; end
            1: begin c.sat_low = 8'd200; c.sat_high = 8'd100; end
            default: begin c.val_low = 8'd255; c.val_high = 8'd0; end
         endcase
         apply_config(c);
         align_frame();
         repeat (2) send_pixel(random_pixel());
      end
   endtask

   // zero geometry makes every pixel its own frame
   task automatic test_hue_beyond_range();
      hcml_csr_type c;
      c = '{hue_low: 8'd180, hue_high: 8'd255, sat_low: 8'd0, sat_high: 8'd255,
            val_low: 8'd0, val_high: 8'd255, frame_width: 11'd0, frame_height: 11'd0};
      apply_config(c);
      send_pixel('{255, 0, 0, 9});
      c.hue_low = 8'd0;
      apply_config(c);
      send_pixel('{0, 255, 0, 99});
   endtask

   // width past the maximum saturates to one full-length row
   task automatic test_wide_row();
      hcml_csr_type c;
      bgra_type target;
      target = random_pixel();
      c = bounds_around(target);
      c.frame_width = 11'd2047;
      c.frame_height = 11'd1;
      apply_config(c);
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      align_frame();
      repeat (MAX_W) send_pixel(phase_pixel(target));
   endtask

   task automatic test_random_frames();
      hcml_csr_type c;
      bgra_type target;
      int n, w, hgt;
      while (pixels_sent < PIXEL_TARGET) begin
         target = random_pixel();
         c = bounds_around(target);
         c.frame_width = small_dim(8);
         c.frame_height = small_dim(4);
         gaps_on = $urandom_range(0, 3) != 0;
         stalls_on = $urandom_range(0, 3) != 0;
         apply_config(c);
         w = clamp_dim(int'(c.frame_width), MAX_W);
         hgt = clamp_dim(int'(c.frame_height), MAX_H);
         // partial phases leave the frame open across the next geometry change
         n = ($urandom_range(0, 3) != 0) ? w * hgt * $urandom_range(1, 3)
                                         : $urandom_range(1, 20);
         repeat (n) send_pixel(phase_pixel(target));
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = REG_HUE_LOW;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.pix_blue = '0;
      req_ch.pix_green = '0;
      req_ch.pix_red = '0;
      req_ch.pix_alpha = '0;
      rsp_ch.ready = 1'b0;
      cfg_model = CSR_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_geometry_change();
      test_full_range_colors();
      test_crossed_bounds();
      test_hue_beyond_range();
      test_wide_row();
      test_random_frames();
      settle_block();

      $display("checked %0d pixels (%0d in bounds) and %0d frame reports", pixels_sent,
               hits_seen, frames_seen);
      $display("%0d register writes covered open, narrow, crossed and odd geometries",
               csr_writes);
      if (errors == 0) begin
         $display("hsv_color_mask_row_locator_unit regression: pass");
      end else begin
         $display("hsv_color_mask_row_locator_unit regression: fail");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("%0t: timeout with %0d transactions outstanding", $time, pending_pixels.size());
      $display("hsv_color_mask_row_locator_unit regression: fail");
      $finish;
   end

endmodule
